@@ design/lue_pkg.sv @@
`timescale 1ns / 1ps

package lue_pkg;

    // sizes of the line store
    localparam int MAX_LINES = 1024;
    localparam int IDX_W     = $clog2(MAX_LINES);
    localparam int CNT_W     = IDX_W + 1;
    localparam int VAL_W     = 31;

    // input function codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;

    // one line with its arrival index, as kept in the sort and stack memories
    typedef struct packed {
        logic [VAL_W-1:0] slope;
        logic [VAL_W-1:0] intercept;
        logic [IDX_W-1:0] idx;
    } line_key_t;

    localparam int KEY_W = $bits(line_key_t);

endpackage

@@ design/lue_in_if.sv @@
`timescale 1ns / 1ps

interface lue_in_if;
    import lue_pkg::*;

    logic             valid;
    logic             ready;
    logic             func;
    logic [VAL_W-1:0] intercept;
    logic [VAL_W-1:0] slope;
    logic             is_last;

    modport source (output valid, func, intercept, slope, is_last, input ready);
    modport sink (input valid, func, intercept, slope, is_last, output ready);
endinterface

@@ design/lue_out_if.sv @@
`timescale 1ns / 1ps

interface lue_out_if;
    import lue_pkg::*;

    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] hull_size;
    logic [CNT_W-1:0] line_id;
    logic             final_id;

    modport source (output valid, hull_size, line_id, final_id, input ready);
    modport sink (input valid, hull_size, line_id, final_id, output ready);
endinterface

@@ design/lue_ram.sv @@
`timescale 1ns / 1ps

module lue_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds data while idle
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ design/lue_cross.sv @@
`timescale 1ns / 1ps

module lue_cross
    import lue_pkg::*;
(
    input  logic      clk,
    input  line_key_t below,
    input  line_key_t top,
    input  line_key_t cand,
    output logic      pop
);

    logic signed [VAL_W:0]       dk1_reg, db1_reg, dk2_reg, db2_reg;
    logic signed [2*VAL_W+1:0]   p1_reg, p2_reg;

    // stage one: differences against the line below the top
    always_ff @(posedge clk)
    begin
        dk1_reg <= $signed({1'b0, cand.slope}) - $signed({1'b0, below.slope});
        db1_reg <= $signed({1'b0, cand.intercept}) - $signed({1'b0, below.intercept});
        dk2_reg <= $signed({1'b0, top.slope}) - $signed({1'b0, below.slope});
        db2_reg <= $signed({1'b0, top.intercept}) - $signed({1'b0, below.intercept});
    end

    // stage two: the two cross products
    always_ff @(posedge clk)
    begin
        p1_reg <= dk1_reg * db2_reg;
        p2_reg <= db1_reg * dk2_reg;
    end

    // positive cross product means the top is hidden
    assign pop = (p1_reg > p2_reg);

endmodule

@@ design/line_upper_envelope_core.sv @@
`timescale 1ns / 1ps
// line_upper_envelope_core: upper envelope of straight lines
// items channel: func 0 loads a line (slope, intercept), numbered from 1 by
//   arrival; is_last on a load closes the set and starts the envelope pass.
//   func 1 fetches the next surviving line id of the last closed set.
// results channel: one transfer per fetch with hull_size, line_id and
//   final_id; line_id 0 with final_id 1 once the ids are exhausted.
// steps: a load of the n-th line is bounded by the insertion into the sorted
//   key memory (one read and one write per step).
//   Closing a set of n lines adds the sort walk, the stack pop tests through
//   the cross product pipeline (a pop that leaves at least two lines
//   refetches the line below) and the id scan of the flag memory.
//   A fetch goes through the result memory read port.
// items.ready is high only while the controller is idle; a load is taken
//   while a result still waits, a fetch then waits for the output register.
// reset clears all counters, so a fetch before any set returns hull_size 0,
//   line_id 0, final_id 1. Memories need no clearing pass.
// a stalled receiver holds the result register and blocks further fetches.

module line_upper_envelope_core
    import lue_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    lue_in_if.sink    items,
    lue_out_if.source results
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FRD   = 4'd1;
    localparam logic [3:0] S_INS   = 4'd2;
    localparam logic [3:0] S_INSC  = 4'd3;
    localparam logic [3:0] S_HRD   = 4'd4;
    localparam logic [3:0] S_HGRP  = 4'd5;
    localparam logic [3:0] S_HCHK  = 4'd6;
    localparam logic [3:0] S_HD    = 4'd7;
    localparam logic [3:0] S_HM    = 4'd8;
    localparam logic [3:0] S_HC    = 4'd9;
    localparam logic [3:0] S_HBRD  = 4'd10;
    localparam logic [3:0] S_HDROP = 4'd11;
    localparam logic [3:0] S_SRD   = 4'd12;
    localparam logic [3:0] S_SWR   = 4'd13;

    localparam logic [CNT_W-1:0] ONE   = CNT_W'(1);
    localparam logic [CNT_W-1:0] TWO   = CNT_W'(2);
    localparam logic [CNT_W-1:0] THREE = CNT_W'(3);
    localparam logic [CNT_W-1:0] FULL  = CNT_W'(MAX_LINES);

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] size_reg, size_next;
    logic [CNT_W-1:0] emit_reg, emit_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] ko_reg, ko_next;
    logic             last_reg, last_next;
    line_key_t        new_reg, new_next;
    line_key_t        l_reg, l_next;
    line_key_t        tk_reg, tk_next;
    line_key_t        bk_reg, bk_next;
    logic [VAL_W-1:0] gs_reg, gs_next;
    logic [VAL_W-1:0] gm_reg, gm_next;
    logic             ov_reg, ov_next;
    logic [CNT_W-1:0] oh_reg, oh_next;
    logic [CNT_W-1:0] oid_reg, oid_next;
    logic             ofin_reg, ofin_next;

    logic             srt_we, srt_re;
    logic [IDX_W-1:0] srt_waddr, srt_raddr;
    line_key_t        srt_wdata, srt_rdata;
    logic             stk_we, stk_re;
    logic [IDX_W-1:0] stk_waddr, stk_raddr;
    line_key_t        stk_wdata, stk_rdata;
    logic             flg_we, flg_re;
    logic [IDX_W-1:0] flg_waddr, flg_raddr;
    logic             flg_wdata, flg_rdata;
    logic             res_we, res_re;
    logic [IDX_W-1:0] res_waddr, res_raddr;
    logic [IDX_W-1:0] res_wdata, res_rdata;
    logic             pop;
    logic [CNT_W-1:0] hi_m3;

    function automatic logic goes_before(line_key_t a, line_key_t b);
        goes_before = (a.slope > b.slope) ||
                      ((a.slope == b.slope) && (a.intercept > b.intercept));
    endfunction

    // sorted keys, envelope stack, kept flags, surviving ids
    lue_ram #(.WIDTH(KEY_W), .DEPTH(MAX_LINES)) u_sort (
        .clk(clk), .we(srt_we), .waddr(srt_waddr), .wdata(srt_wdata),
        .re(srt_re), .raddr(srt_raddr), .rdata(srt_rdata)
    );
    lue_ram #(.WIDTH(KEY_W), .DEPTH(MAX_LINES)) u_stack (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .re(stk_re), .raddr(stk_raddr), .rdata(stk_rdata)
    );
    lue_ram #(.WIDTH(1), .DEPTH(MAX_LINES)) u_flags (
        .clk(clk), .we(flg_we), .waddr(flg_waddr), .wdata(flg_wdata),
        .re(flg_re), .raddr(flg_raddr), .rdata(flg_rdata)
    );
    lue_ram #(.WIDTH(IDX_W), .DEPTH(MAX_LINES)) u_result (
        .clk(clk), .we(res_we), .waddr(res_waddr), .wdata(res_wdata),
        .re(res_re), .raddr(res_raddr), .rdata(res_rdata)
    );

    // pop test on below, top and candidate
    lue_cross u_cross (
        .clk(clk), .below(bk_reg), .top(tk_reg), .cand(l_reg), .pop(pop)
    );

    assign hi_m3 = hi_reg - THREE;

    assign items.ready       = (state_reg == S_IDLE);
    assign results.valid     = ov_reg;
    assign results.hull_size = oh_reg;
    assign results.line_id   = oid_reg;
    assign results.final_id  = ofin_reg;

    // controller
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        size_next  = size_reg;
        emit_next  = emit_reg;
        hi_next    = hi_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        ko_next    = ko_reg;
        last_next  = last_reg;
        new_next   = new_reg;
        l_next     = l_reg;
        tk_next    = tk_reg;
        bk_next    = bk_reg;
        gs_next    = gs_reg;
        gm_next    = gm_reg;
        ov_next    = ov_reg;
        oh_next    = oh_reg;
        oid_next   = oid_reg;
        ofin_next  = ofin_reg;
        srt_we = 1'b0; srt_re = 1'b0; srt_waddr = '0; srt_raddr = '0; srt_wdata = '0;
        stk_we = 1'b0; stk_re = 1'b0; stk_waddr = '0; stk_raddr = '0; stk_wdata = '0;
        flg_we = 1'b0; flg_re = 1'b0; flg_waddr = '0; flg_raddr = '0; flg_wdata = 1'b0;
        res_we = 1'b0; res_re = 1'b0; res_waddr = '0; res_raddr = '0; res_wdata = '0;

        // output transfer frees the register
        if (ov_reg && results.ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (items.valid)
                begin
                    if (items.func == FUNC_FETCH)
                    begin
                        res_re     = 1'b1;
                        res_raddr  = emit_reg[IDX_W-1:0];
                        state_next = S_FRD;
                    end
                    else
                    begin
                        last_next = items.is_last;
                        if (cnt_reg < FULL)
                        begin
                            new_next.slope     = items.slope;
                            new_next.intercept = items.intercept;
                            new_next.idx       = cnt_reg[IDX_W-1:0];
                            // clear the kept flag of the new line
                            flg_we     = 1'b1;
                            flg_waddr  = cnt_reg[IDX_W-1:0];
                            flg_wdata  = 1'b0;
                            j_next     = cnt_reg;
                            state_next = S_INS;
                        end
                        else if (items.is_last)
                        begin
                            i_next     = '0;
                            hi_next    = '0;
                            state_next = S_HRD;
                        end
                    end
                end
            end
            S_FRD:
            begin
                if (!ov_reg || results.ready)
                begin
                    ov_next = 1'b1;
                    oh_next = size_reg;
                    if (emit_reg < size_reg)
                    begin
                        oid_next  = {1'b0, res_rdata} + ONE;
                        ofin_next = ((emit_reg + ONE) == size_reg);
                        emit_next = emit_reg + ONE;
                    end
                    else
                    begin
                        oid_next  = '0;
                        ofin_next = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            S_INS:
            begin
                if (j_reg == '0)
                begin
                    srt_we    = 1'b1;
                    srt_waddr = '0;
                    srt_wdata = new_reg;
                    cnt_next  = cnt_reg + ONE;
                    i_next    = '0;
                    hi_next   = '0;
                    state_next = last_reg ? S_HRD : S_IDLE;
                end
                else
                begin
                    srt_re     = 1'b1;
                    srt_raddr  = IDX_W'(j_reg - ONE);
                    state_next = S_INSC;
                end
            end
            S_INSC:
            begin
                srt_we    = 1'b1;
                srt_waddr = j_reg[IDX_W-1:0];
                if (goes_before(new_reg, srt_rdata))
                begin
                    // shift the earlier key up one place
                    srt_wdata  = srt_rdata;
                    j_next     = j_reg - ONE;
                    state_next = S_INS;
                end
                else
                begin
                    srt_wdata  = new_reg;
                    cnt_next   = cnt_reg + ONE;
                    i_next     = '0;
                    hi_next    = '0;
                    state_next = last_reg ? S_HRD : S_IDLE;
                end
            end
            S_HRD:
            begin
                if (i_reg == cnt_reg)
                begin
                    i_next     = '0;
                    ko_next    = '0;
                    state_next = S_SRD;
                end
                else
                begin
                    srt_re     = 1'b1;
                    srt_raddr  = i_reg[IDX_W-1:0];
                    state_next = S_HGRP;
                end
            end
            S_HGRP:
            begin
                l_next = srt_rdata;
                if ((i_reg == '0) || (srt_rdata.slope != gs_reg))
                begin
                    gs_next    = srt_rdata.slope;
                    gm_next    = srt_rdata.intercept;
                    state_next = S_HCHK;
                end
                else if (srt_rdata.intercept != gm_reg)
                begin
                    // lower duplicate of a slope takes no part
                    i_next     = i_reg + ONE;
                    state_next = S_HRD;
                end
                else
                begin
                    state_next = S_HCHK;
                end
            end
            S_HCHK:
            begin
                state_next = (hi_reg > ONE) ? S_HD : S_HDROP;
            end
            S_HD:
            begin
                state_next = S_HM;
            end
            S_HM:
            begin
                state_next = S_HC;
            end
            S_HC:
            begin
                if (pop)
                begin
                    flg_we    = 1'b1;
                    flg_waddr = tk_reg.idx;
                    flg_wdata = 1'b0;
                    tk_next   = bk_reg;
                    hi_next   = hi_reg - ONE;
                    if (hi_reg > TWO)
                    begin
                        // fetch the new line below the top
                        stk_re     = 1'b1;
                        stk_raddr  = hi_m3[IDX_W-1:0];
                        state_next = S_HBRD;
                    end
                    else
                    begin
                        state_next = S_HCHK;
                    end
                end
                else
                begin
                    state_next = S_HDROP;
                end
            end
            S_HBRD:
            begin
                bk_next    = stk_rdata;
                state_next = S_HCHK;
            end
            S_HDROP:
            begin
                i_next     = i_reg + ONE;
                state_next = S_HRD;
                if (!((hi_reg != '0) && (l_reg.slope < tk_reg.slope) &&
                      (l_reg.intercept < tk_reg.intercept)))
                begin
                    // push the candidate
                    stk_we    = 1'b1;
                    stk_waddr = hi_reg[IDX_W-1:0];
                    stk_wdata = l_reg;
                    flg_we    = 1'b1;
                    flg_waddr = l_reg.idx;
                    flg_wdata = 1'b1;
                    bk_next   = tk_reg;
                    tk_next   = l_reg;
                    hi_next   = hi_reg + ONE;
                end
            end
            S_SRD:
            begin
                if (i_reg == cnt_reg)
                begin
                    size_next  = ko_reg;
                    emit_next  = '0;
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    flg_re     = 1'b1;
                    flg_raddr  = i_reg[IDX_W-1:0];
                    state_next = S_SWR;
                end
            end
            S_SWR:
            begin
                if (flg_rdata)
                begin
                    res_we    = 1'b1;
                    res_waddr = ko_reg[IDX_W-1:0];
                    res_wdata = i_reg[IDX_W-1:0];
                    ko_next   = ko_reg + ONE;
                end
                i_next     = i_reg + ONE;
                state_next = S_SRD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            size_reg  <= '0;
            emit_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            size_reg  <= size_next;
            emit_reg  <= emit_next;
            ov_reg    <= ov_next;
        end
    end

    // working registers and output payload
    always_ff @(posedge clk)
    begin
        hi_reg   <= hi_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        ko_reg   <= ko_next;
        last_reg <= last_next;
        new_reg  <= new_next;
        l_reg    <= l_next;
        tk_reg   <= tk_next;
        bk_reg   <= bk_next;
        gs_reg   <= gs_next;
        gm_reg   <= gm_next;
        oh_reg   <= oh_next;
        oid_reg  <= oid_next;
        ofin_reg <= ofin_next;
    end

endmodule

@@ design/lue_checker.sv @@
`timescale 1ns / 1ps

module lue_checker
    import lue_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             res_valid,
    input logic             res_ready,
    input logic [CNT_W-1:0] res_hull_size,
    input logic [CNT_W-1:0] res_line_id,
    input logic             res_final_id
);

    // a pending result stays offered
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its id
    a_id_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_line_id))
        else $error("result id changed while stalled");

    // an exhausted fetch is always marked final
    a_none_final: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_line_id == '0) |-> res_final_id)
        else $error("empty id without final mark");

    // ids and size stay within the line store
    a_id_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_line_id <= CNT_W'(MAX_LINES)) &&
                      (res_hull_size <= CNT_W'(MAX_LINES)))
        else $error("id or size beyond line store");

endmodule

bind line_upper_envelope_core lue_checker u_lue_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (results.valid),
    .res_ready     (results.ready),
    .res_hull_size (results.hull_size),
    .res_line_id   (results.line_id),
    .res_final_id  (results.final_id)
);

@@ verif/envelope_checker.sv @@
`timescale 1ns / 1ps

module envelope_checker
    import lue_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    lue_in_if     items,
    lue_out_if    results,
    output int    fail_count,
    output int    pending_fetches,
    output int    results_seen
);

    typedef struct {
        logic [CNT_W-1:0] hull_size;
        logic [CNT_W-1:0] line_id;
        logic             final_id;
    } fetch_reply_t;

    // line data of the open set and hull of the last closed set
    longint       set_slope[$];
    longint       set_icpt[$];
    int           hull_ids[$];
    int           fetch_ptr;
    fetch_reply_t expected_replies[$];

    function automatic bit sorts_ahead(int a, int b);
        if (set_slope[a] != set_slope[b]) return set_slope[a] > set_slope[b];
        if (set_icpt[a] != set_icpt[b]) return set_icpt[a] > set_icpt[b];
        return a < b;
    endfunction

    // cross product of (c - a) and (b - a) is positive
    function automatic bit bends_inward(int a, int b, int c);
        longint dk1, db1, dk2, db2;
        dk1 = set_slope[c] - set_slope[a];
        db1 = set_icpt[c] - set_icpt[a];
        dk2 = set_slope[b] - set_slope[a];
        db2 = set_icpt[b] - set_icpt[a];
        return dk1 * db2 > db1 * dk2;
    endfunction

    // sort, keep group maxima, stack pass, then ids in arrival order
    function automatic void build_hull();
        int order[$];
        int stack[$];
        bit kept[];
        int n, j, v, idx;
        longint grp_slope, grp_max;
        n = set_slope.size();
        for (int i = 0; i < n; i++) order.push_back(i);
        for (int i = 1; i < n; i++)
        begin
            v = order[i];
            j = i;
            while (j > 0 && sorts_ahead(v, order[j-1]))
            begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = v;
        end
        grp_slope = 0;
        grp_max = 0;
        for (int i = 0; i < n; i++)
        begin
            idx = order[i];
            if (i == 0 || set_slope[idx] != grp_slope)
            begin
                grp_slope = set_slope[idx];
                grp_max = set_icpt[idx];
            end
            else if (set_icpt[idx] != grp_max)
                continue;
            while (stack.size() > 1 &&
                   bends_inward(stack[stack.size()-2], stack[stack.size()-1], idx))
                void'(stack.pop_back());
            if (stack.size() > 0 &&
                set_slope[idx] < set_slope[stack[$]] &&
                set_icpt[idx] < set_icpt[stack[$]])
                continue;
            stack.push_back(idx);
        end
        kept = new[n];
        foreach (stack[k]) kept[stack[k]] = 1'b1;
        hull_ids.delete();
        for (int i = 0; i < n; i++)
            if (kept[i]) hull_ids.push_back(i + 1);
        fetch_ptr = 0;
        set_slope.delete();
        set_icpt.delete();
    endfunction

    assign pending_fetches = expected_replies.size();

    // predict on item transfers, compare on result transfers
    always @(posedge clk or negedge rst_n)
    begin
        fetch_reply_t exp_r;
        if (!rst_n)
        begin
            fail_count <= 0;
            results_seen <= 0;
            set_slope.delete();
            set_icpt.delete();
            hull_ids.delete();
            fetch_ptr = 0;
            expected_replies.delete();
        end
        else
        begin
            if (items.valid && items.ready)
            begin
                if (items.func == FUNC_LOAD)
                begin
                    if (set_slope.size() < MAX_LINES)
                    begin
                        set_slope.push_back(longint'(items.slope));
                        set_icpt.push_back(longint'(items.intercept));
                    end
                    if (items.is_last) build_hull();
                end
                else
                begin
                    exp_r.hull_size = CNT_W'(hull_ids.size());
                    if (fetch_ptr < hull_ids.size())
                    begin
                        exp_r.line_id = CNT_W'(hull_ids[fetch_ptr]);
                        exp_r.final_id = (fetch_ptr + 1 == hull_ids.size());
                        fetch_ptr++;
                    end
                    else
                    begin
                        exp_r.line_id = '0;
                        exp_r.final_id = 1'b1;
                    end
                    expected_replies.push_back(exp_r);
                end
            end
            if (results.valid && results.ready)
            begin
                results_seen <= results_seen + 1;
                if (expected_replies.size() == 0)
                begin
                    $display("%0t: unexpected result hull_size=%0d line_id=%0d final_id=%0d",
                             $time, results.hull_size, results.line_id, results.final_id);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = expected_replies.pop_front();
                    if (results.hull_size !== exp_r.hull_size ||
                        results.line_id !== exp_r.line_id ||
                        results.final_id !== exp_r.final_id)
                    begin
                        $display("%0t: exp size=%0d id=%0d fin=%0d got size=%0d id=%0d fin=%0d",
                                 $time, exp_r.hull_size, exp_r.line_id, exp_r.final_id,
                                 results.hull_size, results.line_id, results.final_id);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

@@ verif/line_upper_envelope_core_test.sv @@
`timescale 1ns / 1ps

module line_upper_envelope_core_test;
    import lue_pkg::*;

    localparam int IDLE_LIMIT = 200000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_fetches;
    int   results_seen;
    int   idle_cycles;
    int   burst_left;
    int   sets_closed;
    int   items_sent;
    int   stall_phase;

    lue_in_if  items ();
    lue_out_if results ();

    line_upper_envelope_core u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items.sink),
        .results (results.source)
    );

    envelope_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .items           (items),
        .results         (results),
        .fail_count      (fail_count),
        .pending_fetches (pending_fetches),
        .results_seen    (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver stall pattern: long ready stretches, then stall windows
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            results.ready <= 1'b0;
            stall_phase <= 0;
        end
        else
        begin
            stall_phase <= (stall_phase + 1) % 64;
            if (stall_phase < 24)
                results.ready <= 1'b1;
            else if (stall_phase < 40)
                results.ready <= ($urandom_range(0, 3) != 0);
            else
                results.ready <= ($urandom_range(0, 3) == 0);
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge clk)
    begin
        if ((items.valid && items.ready) || (results.valid && results.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // one item transfer, with random gaps between bursts
    task automatic send_item(input logic fn, input logic [VAL_W-1:0] icpt,
                             input logic [VAL_W-1:0] slp, input logic last);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0)
            begin
                items.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        burst_left--;
        items.valid <= 1'b1;
        items.func <= fn;
        items.intercept <= icpt;
        items.slope <= slp;
        items.is_last <= last;
        @(posedge clk);
        while (!items.ready) @(posedge clk);
        items_sent++;
        if (fn == FUNC_LOAD && last) sets_closed++;
    endtask

    task automatic load_line(input logic [VAL_W-1:0] icpt, input logic [VAL_W-1:0] slp,
                             input logic last);
        send_item(FUNC_LOAD, icpt, slp, last);
    endtask

    task automatic fetch_ids(input int count);
        repeat (count)
            send_item(FUNC_FETCH, VAL_W'($urandom), VAL_W'($urandom),
                      1'($urandom_range(0, 1)));
    endtask

    function automatic logic [VAL_W-1:0] rand_value(input int range_sel);
        case (range_sel)
            0: return VAL_W'($urandom_range(0, 7));
            1: return {VAL_W{1'b1}} - VAL_W'($urandom_range(0, 3));
            2: return VAL_W'($urandom_range(0, 1000));
            default: return VAL_W'($urandom);
        endcase
    endfunction

    initial
    begin
        int n, sel_k, sel_b;
        rst_n = 1'b0;
        items.valid = 1'b0;
        items.func = FUNC_LOAD;
        items.intercept = '0;
        items.slope = '0;
        items.is_last = 1'b0;
        idle_cycles = 0;
        burst_left = 0;
        sets_closed = 0;
        items_sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fetch before any set
        fetch_ids(2);
        // extremes, equal slopes with lower duplicates, dominated line
        load_line({VAL_W{1'b1}}, {VAL_W{1'b1}}, 1'b0);
        load_line('0, '0, 1'b0);
        load_line(31'd5, 31'd5, 1'b0);
        load_line(31'd9, 31'd5, 1'b0);
        load_line(31'd9, 31'd5, 1'b0);
        load_line(31'd3, 31'd2, 1'b0);
        load_line({VAL_W{1'b1}}, '0, 1'b1);
        fetch_ids(3);
        // load during fetching opens a new set; old hull stays fetchable
        load_line(31'd1, 31'd1, 1'b0);
        fetch_ids(5);
        load_line(31'd1, 31'd1, 1'b1);
        fetch_ids(3);
        // single-line set
        load_line(31'h2AAAAAAA, 31'h55555555, 1'b1);
        fetch_ids(2);

        // wait for every result before going on
        items.valid <= 1'b0;
        while (pending_fetches != 0) @(posedge clk);

        // random sets: mostly small, full set walked then a few past the end
        while (items_sent < 650)
        begin
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
            sel_k = $urandom_range(0, 3);
            sel_b = $urandom_range(0, 3);
            for (int i = 0; i < n; i++)
                load_line(rand_value(sel_b), rand_value(sel_k), i == n - 1);
            fetch_ids(n + $urandom_range(0, 2));
        end

        items.valid <= 1'b0;
        while (pending_fetches != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("ran %0d items in %0d closed sets, %0d results checked",
                 items_sent, sets_closed, results_seen);
        $display("covered extreme values, tied slopes, dominated lines and past-end fetches");
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
